### hdl/ncff_pkg.sv
`default_nettype none

package ncff_pkg;

  // Fixed-point scale of the coordinate input (degrees * 10^7)
  localparam int unsigned CoordScale = 10000000;
  localparam logic [31:0] LatLimitE7 = 32'd900000000;

  // Reciprocal of 10^7, scaled by 2^55, exact for inputs below 2^31 + 1
  localparam int unsigned RecipE7Shift = 55;
  localparam logic [31:0] RecipE7      = 32'd3602879702;

  // Reciprocal of 1000, scaled by 2^34, exact for inputs below 2^24
  localparam int unsigned RecipE3Shift = 34;
  localparam logic [24:0] RecipE3      = 25'd17179870;

  localparam logic [23:0] RoundHalf   = 24'd500;
  localparam logic [13:0] Min4Wrap    = 14'd10000;
  localparam logic [5:0]  MinutesWrap = 6'd60;

  // ASCII codes
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChN     = 8'h4e;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChW     = 8'h57;

  // Character slots of a field; latitude starts at the tens of degrees
  localparam logic [3:0] PosDegH  = 4'd0;
  localparam logic [3:0] PosDegT  = 4'd1;
  localparam logic [3:0] PosDegO  = 4'd2;
  localparam logic [3:0] PosMinT  = 4'd3;
  localparam logic [3:0] PosMinO  = 4'd4;
  localparam logic [3:0] PosDot   = 4'd5;
  localparam logic [3:0] PosFrac3 = 4'd6;
  localparam logic [3:0] PosFrac2 = 4'd7;
  localparam logic [3:0] PosFrac1 = 4'd8;
  localparam logic [3:0] PosFrac0 = 4'd9;
  localparam logic [3:0] PosComma = 4'd10;
  localparam logic [3:0] PosHemi  = 4'd11;

  // Decimal digits of one formatted field
  typedef struct packed {
    logic       lon;
    logic       neg;
    logic [3:0] deg_h;
    logic [3:0] deg_t;
    logic [3:0] deg_o;
    logic [3:0] min_t;
    logic [3:0] min_o;
    logic [3:0] frac3;
    logic [3:0] frac2;
    logic [3:0] frac1;
    logic [3:0] frac0;
  } digits_t;

  // Quotient by ten for values below 128
  function automatic logic [3:0] div10(input logic [6:0] x);
    logic [14:0] p;
    p = {8'b0, x} * 15'd205;
    return p[14:11];
  endfunction

  // Remainder by ten for values below 128
  function automatic logic [3:0] mod10(input logic [6:0] x);
    logic [6:0] q10;
    q10 = {3'b0, div10(x)} * 7'd10;
    return 4'(x - q10);
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return ChZero + {4'b0, d};
  endfunction

endpackage

`default_nettype wire

### hdl/nmea_coordinate_field_formatter_core.sv
`default_nettype none

// Formats one signed coordinate (degrees * 10^7 on s_axis_tdata, latitude or
// longitude selected by s_axis_tuser) into the NMEA text field ddmm.mmmm,H or
// dddmm.mmmm,H, one ASCII character per output transaction, tlast on the
// hemisphere letter. Minutes are rounded half up to four decimals; latitude
// above 90 degrees is clamped. A coordinate passes a seven-stage arithmetic
// pipeline (two reciprocal multiplies by 10^-7, one by 10^-3, then digit
// split) before the character serializer takes it. The serializer sends one
// character per cycle while the output is ready, so an item occupies the
// output for 11 characters (latitude) or 12 characters (longitude); items
// follow back to back, the next loaded as the hemisphere letter is taken,
// while the pipeline takes the next items in behind it.
module nmea_coordinate_field_formatter_core
  import ncff_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] coord_e7
  input  wire logic        s_axis_tuser,   // [0] req_type
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] ascii_char
  output      logic        m_axis_tlast    // last_char
);

  // Pipeline control
  logic [6:0] v_q;
  logic       adv;
  logic       load;

  // Serializer state
  logic       busy_q;
  logic [3:0] idx_q;
  digits_t    rec_q;

  // Stage payloads
  logic        lon1_q, neg1_q;
  logic [31:0] mag1_q;
  logic        lon2_q, neg2_q;
  logic [31:0] mag2_q;
  logic [7:0]  deg2_q;
  logic        lon3_q, neg3_q;
  logic [7:0]  deg3_q;
  logic [29:0] mine7_3_q;
  logic        lon4_q, neg4_q;
  logic [7:0]  deg4_q;
  logic [29:0] mine7_4_q;
  logic [5:0]  min4_q;
  logic        lon5_q, neg5_q;
  logic [7:0]  deg5_q;
  logic [5:0]  min5_q;
  logic [23:0] rem5_q;
  logic        lon6_q, neg6_q;
  logic [7:0]  deg6_q;
  logic [5:0]  min6_q;
  logic [13:0] frac6_q;
  digits_t     dig7_q;

  // Stage logic signals
  logic        in_neg;
  logic [31:0] in_mag, in_abs;
  logic [63:0] deg_prod;
  logic [23:0] s3_frac;
  logic [31:0] s3_degscaled;
  logic [29:0] s3_mine7;
  logic [63:0] min_prod;
  logic [29:0] s5_minscaled;
  logic [23:0] s5_rem;
  logic [48:0] r_prod;
  logic [13:0] s6_min4, s6_min4w;
  logic        s6_c1, s6_c2;
  logic [5:0]  s6_min1, s6_minw;
  logic [7:0]  s6_deg;
  logic [1:0]  s7_degh;
  logic [6:0]  s7_degr;
  logic [27:0] s7_q3p;
  logic [3:0]  s7_q3;
  logic [9:0]  s7_r3;
  logic [15:0] s7_q2p;
  logic [3:0]  s7_q2;
  logic [6:0]  s7_r2;
  digits_t     s7_dig;

  // Advance the whole pipeline unless its last stage holds an unsent item
  assign load          = v_q[6] && (!busy_q || (m_axis_tready && idx_q == PosHemi));
  assign adv           = !v_q[6] || load;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[5:0], s_axis_tvalid};
    end
  end

  // Stage 1: magnitude and latitude clamp
  always_comb begin
    in_neg = s_axis_tdata[31];
    in_abs = in_neg ? (32'd0 - s_axis_tdata) : s_axis_tdata;
    in_mag = (!s_axis_tuser && in_abs > LatLimitE7) ? LatLimitE7 : in_abs;
  end

  // Stage 2: whole degrees
  assign deg_prod = {32'b0, mag1_q} * {32'b0, RecipE7};

  // Stage 3: fraction of a degree in 10^-7 minutes units
  always_comb begin
    s3_degscaled = {24'b0, deg2_q} * 32'(CoordScale);
    s3_frac      = 24'(mag2_q - s3_degscaled);
    s3_mine7     = {s3_frac, 6'b0} - {4'b0, s3_frac, 2'b0};
  end

  // Stage 4: whole minutes
  assign min_prod = {34'b0, mine7_3_q} * {32'b0, RecipE7};

  // Stage 5: minute remainder
  always_comb begin
    s5_minscaled = {24'b0, min4_q} * 30'(CoordScale);
    s5_rem       = 24'(mine7_4_q - s5_minscaled);
  end

  // Stage 6: round to four decimals and carry into minutes and degrees
  always_comb begin
    r_prod   = {25'b0, rem5_q + RoundHalf} * {24'b0, RecipE3};
    s6_min4  = r_prod[RecipE3Shift+13:RecipE3Shift];
    s6_c1    = s6_min4 >= Min4Wrap;
    s6_min4w = s6_c1 ? (s6_min4 - Min4Wrap) : s6_min4;
    s6_min1  = min5_q + {5'b0, s6_c1};
    s6_c2    = s6_min1 >= MinutesWrap;
    s6_minw  = s6_c2 ? (s6_min1 - MinutesWrap) : s6_min1;
    s6_deg   = deg5_q + {7'b0, s6_c2};
  end

  // Stage 7: split into decimal digits
  always_comb begin
    s7_degh = (deg6_q >= 8'd200) ? 2'd2 : ((deg6_q >= 8'd100) ? 2'd1 : 2'd0);
    s7_degr = 7'(deg6_q - 8'(s7_degh) * 8'd100);
    s7_q3p  = {14'b0, frac6_q} * 28'd8389;
    s7_q3   = s7_q3p[26:23];
    s7_r3   = 10'(frac6_q - 14'(s7_q3) * 14'd1000);
    s7_q2p  = {6'b0, s7_r3} * 16'd41;
    s7_q2   = s7_q2p[15:12];
    s7_r2   = 7'(s7_r3 - 10'(s7_q2) * 10'd100);
    s7_dig.lon   = lon6_q;
    s7_dig.neg   = neg6_q;
    s7_dig.deg_h = {2'b0, s7_degh};
    s7_dig.deg_t = div10(s7_degr);
    s7_dig.deg_o = mod10(s7_degr);
    s7_dig.min_t = div10({1'b0, min6_q});
    s7_dig.min_o = mod10({1'b0, min6_q});
    s7_dig.frac3 = s7_q3;
    s7_dig.frac2 = s7_q2;
    s7_dig.frac1 = div10(s7_r2);
    s7_dig.frac0 = mod10(s7_r2);
  end

  // Hold stage payloads while the pipeline is stalled
  always_ff @(posedge clk_i) begin
    if (adv) begin
      lon1_q    <= s_axis_tuser;
      neg1_q    <= in_neg;
      mag1_q    <= in_mag;
      lon2_q    <= lon1_q;
      neg2_q    <= neg1_q;
      mag2_q    <= mag1_q;
      deg2_q    <= deg_prod[RecipE7Shift+7:RecipE7Shift];
      lon3_q    <= lon2_q;
      neg3_q    <= neg2_q;
      deg3_q    <= deg2_q;
      mine7_3_q <= s3_mine7;
      lon4_q    <= lon3_q;
      neg4_q    <= neg3_q;
      deg4_q    <= deg3_q;
      mine7_4_q <= mine7_3_q;
      min4_q    <= min_prod[RecipE7Shift+5:RecipE7Shift];
      lon5_q    <= lon4_q;
      neg5_q    <= neg4_q;
      deg5_q    <= deg4_q;
      min5_q    <= min4_q;
      rem5_q    <= s5_rem;
      lon6_q    <= lon5_q;
      neg6_q    <= neg5_q;
      deg6_q    <= s6_deg;
      min6_q    <= s6_minw;
      frac6_q   <= s6_min4w;
      dig7_q    <= s7_dig;
    end
  end

  // Serializer: step one character per output transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= PosDegH;
    end else if (load) begin
      busy_q <= 1'b1;
      idx_q  <= dig7_q.lon ? PosDegH : PosDegT;
    end else if (busy_q && m_axis_tready) begin
      if (idx_q == PosHemi) begin
        busy_q <= 1'b0;
      end else begin
        idx_q <= idx_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rec_q <= dig7_q;
    end
  end

  // Select the character at the current slot
  always_comb begin
    case (idx_q)
      PosDegH:  m_axis_tdata = digit_char(rec_q.deg_h);
      PosDegT:  m_axis_tdata = digit_char(rec_q.deg_t);
      PosDegO:  m_axis_tdata = digit_char(rec_q.deg_o);
      PosMinT:  m_axis_tdata = digit_char(rec_q.min_t);
      PosMinO:  m_axis_tdata = digit_char(rec_q.min_o);
      PosDot:   m_axis_tdata = ChDot;
      PosFrac3: m_axis_tdata = digit_char(rec_q.frac3);
      PosFrac2: m_axis_tdata = digit_char(rec_q.frac2);
      PosFrac1: m_axis_tdata = digit_char(rec_q.frac1);
      PosFrac0: m_axis_tdata = digit_char(rec_q.frac0);
      PosComma: m_axis_tdata = ChComma;
      default: begin
        if (rec_q.lon) begin
          m_axis_tdata = rec_q.neg ? ChW : ChE;
        end else begin
          m_axis_tdata = rec_q.neg ? ChS : ChN;
        end
      end
    endcase
  end

  assign m_axis_tvalid = busy_q;
  assign m_axis_tlast  = (idx_q == PosHemi);

endmodule

`default_nettype wire

### hdl/ncff_checker.sv
`default_nettype none

module ncff_checker
  import ncff_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic [31:0] s_axis_tdata,
  input wire logic        s_axis_tuser,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [7:0]  m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // Hold a stalled input transaction
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input transaction changed while stalled");

  // Hold a stalled output transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output transaction changed while stalled");

  // Close every field with a hemisphere letter
  a_last_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |->
      m_axis_tdata == ChN || m_axis_tdata == ChS ||
      m_axis_tdata == ChE || m_axis_tdata == ChW)
    else $error("field closed without a hemisphere letter");

  // Carry only digits and separators before the letter
  a_body_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tdata >= ChZero && m_axis_tdata <= ChNine) ||
      m_axis_tdata == ChDot || m_axis_tdata == ChComma)
    else $error("unexpected character inside a field");

  // Follow the comma at once with the closing letter
  a_comma_then_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tdata == ChComma |=>
      m_axis_tvalid && m_axis_tlast)
    else $error("comma not followed by the hemisphere letter");

endmodule

bind nmea_coordinate_field_formatter_core ncff_checker u_ncff_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
